// ----- sv/rpap_pkg.sv -----
// Package for the point rotation block: widths, CORDIC constants and tables.
// No dependencies.
package rpap_pkg;

    localparam int CordicStages = 18;
    localparam int FracBits     = 16;
    localparam int TrigFrac     = 28;

    localparam logic signed [31:0] GainQ28    = 32'sd163008219;
    localparam logic signed [63:0] DegToRad   = 64'sd18740330;
    localparam logic signed [26:0] FullTurn   = 27'sd23592960;
    localparam logic signed [26:0] QuarterTurn = 27'sd5898240;
    localparam logic signed [27:0] AngleWrap  = 28'sd23592960;

    typedef logic signed [31:0] t_coord;
    typedef logic signed [31:0] t_trig;

    function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 32'sd843314857;
            5'd1:  atan_q30 = 32'sd497837829;
            5'd2:  atan_q30 = 32'sd263043837;
            5'd3:  atan_q30 = 32'sd133525159;
            5'd4:  atan_q30 = 32'sd67021687;
            5'd5:  atan_q30 = 32'sd33543516;
            5'd6:  atan_q30 = 32'sd16775851;
            5'd7:  atan_q30 = 32'sd8388437;
            5'd8:  atan_q30 = 32'sd4194283;
            5'd9:  atan_q30 = 32'sd2097125;
            5'd10: atan_q30 = 32'sd1048570;
            5'd11: atan_q30 = 32'sd524287;
            5'd12: atan_q30 = 32'sd262143;
            5'd13: atan_q30 = 32'sd131071;
            5'd14: atan_q30 = 32'sd65535;
            5'd15: atan_q30 = 32'sd32767;
            5'd16: atan_q30 = 32'sd16383;
            5'd17: atan_q30 = 32'sd8191;
            5'd18: atan_q30 = 32'sd4095;
            5'd19: atan_q30 = 32'sd2047;
            5'd20: atan_q30 = 32'sd1023;
            5'd21: atan_q30 = 32'sd511;
            5'd22: atan_q30 = 32'sd255;
            5'd23: atan_q30 = 32'sd127;
            5'd24: atan_q30 = 32'sd63;
            5'd25: atan_q30 = 32'sd31;
            5'd26: atan_q30 = 32'sd15;
            5'd27: atan_q30 = 32'sd8;
            5'd28: atan_q30 = 32'sd4;
            5'd29: atan_q30 = 32'sd2;
            5'd30: atan_q30 = 32'sd1;
            default: atan_q30 = 32'sd0;
        endcase
    endfunction

    // Word carried along the pipeline next to the CORDIC state.
    typedef struct packed {
        t_coord             px;
        t_coord             py;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [27:0] ang;
        logic [1:0]         quad;
    } t_side;

endpackage

// ----- sv/rpap_cordic_stage.sv -----
// One registered CORDIC rotation stage with its side word.
// Depends on rpap_pkg.
module rpap_cordic_stage import rpap_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [4:0]         i_idx,
    input  logic               i_valid,
    input  t_trig              i_x,
    input  t_trig              i_y,
    input  logic signed [31:0] i_z,
    input  t_side              i_side,
    output logic               o_valid,
    output t_trig              o_x,
    output t_trig              o_y,
    output logic signed [31:0] o_z,
    output t_side              o_side
);
    logic               r_valid;
    t_trig              r_x, r_y, n_x, n_y;
    logic signed [31:0] r_z, n_z;
    t_side              r_side;

    always_comb begin
        if (!i_z[31]) begin
            n_x = i_x - (i_y >>> i_idx);
            n_y = i_y + (i_x >>> i_idx);
            n_z = i_z - atan_q30(i_idx);
        end else begin
            n_x = i_x + (i_y >>> i_idx);
            n_y = i_y - (i_x >>> i_idx);
            n_z = i_z + atan_q30(i_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;
endmodule

// ----- sv/rpap_front.sv -----
// Front stages: angle reduction to a quadrant, radian conversion, deltas, heading.
// Depends on rpap_pkg.
module rpap_front import rpap_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_coord             i_pivot_x,
    input  t_coord             i_pivot_y,
    input  t_coord             i_point_x,
    input  t_coord             i_point_y,
    input  logic signed [26:0] i_current_angle,
    input  logic signed [25:0] i_rotation,
    output logic               o_valid,
    output logic signed [31:0] o_z,
    output t_side              o_side
);
    // Stage A: theta = -rotation folded once into [0, 360) (exact for |rotation| <= 360), plus deltas and heading.
    logic               r_va;
    logic signed [26:0] r_t;
    t_side              r_sa;
    logic signed [26:0] n_t, neg;
    logic signed [27:0] n_ang;

    always_comb begin
        neg = -27'(i_rotation);
        if (neg < 0) n_t = neg + FullTurn;
        else if (neg >= FullTurn) n_t = neg - FullTurn;
        else n_t = neg;
        n_ang = 28'(i_current_angle);
        if (n_ang > AngleWrap) n_ang = n_ang - AngleWrap;
        n_ang = n_ang + 28'(i_rotation);
    end

    // Stage B: quadrant split and residual in Q30 radians.
    logic               r_vb;
    logic signed [31:0] r_z;
    t_side              r_sb;
    t_side              n_sb;
    logic [1:0]         n_q;
    logic signed [26:0] n_r;
    logic signed [63:0] prod;

    always_comb begin
        if (r_t >= 3 * QuarterTurn) begin
            n_q = 2'd3; n_r = 27'(r_t - 3 * QuarterTurn);
        end else if (r_t >= 2 * QuarterTurn) begin
            n_q = 2'd2; n_r = 27'(r_t - 2 * QuarterTurn);
        end else if (r_t >= QuarterTurn) begin
            n_q = 2'd1; n_r = r_t - QuarterTurn;
        end else begin
            n_q = 2'd0; n_r = r_t;
        end
        prod = 64'(n_r) * DegToRad + (64'sd1 <<< (FracBits - 1));
        n_sb      = r_sa;
        n_sb.quad = n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
        if (i_en) begin
            r_t       <= n_t;
            r_sa.px   <= i_pivot_x;
            r_sa.py   <= i_pivot_y;
            r_sa.dx   <= 33'(i_point_x) - 33'(i_pivot_x);
            r_sa.dy   <= 33'(i_point_y) - 33'(i_pivot_y);
            r_sa.ang  <= n_ang;
            r_sa.quad <= 2'd0;
            r_z       <= 32'(prod >>> FracBits);
            r_sb      <= n_sb;
        end
    end

    assign o_valid = r_vb;
    assign o_z     = r_z;
    assign o_side  = r_sb;
endmodule

// ----- sv/rpap_back.sv -----
// Back stages: quadrant fix, products, rounding, pivot add and saturation.
// Depends on rpap_pkg.
module rpap_back import rpap_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_trig              i_cr,
    input  t_trig              i_sr,
    input  t_side              i_side,
    output logic               o_valid,
    output t_coord             o_rotated_x,
    output t_coord             o_rotated_y,
    output logic signed [27:0] o_new_angle,
    output logic               o_saturated
);
    t_trig c, s;
    always_comb begin
        case (i_side.quad)
            2'd0:    begin c = i_cr;  s = i_sr;  end
            2'd1:    begin c = -i_sr; s = i_cr;  end
            2'd2:    begin c = -i_cr; s = -i_sr; end
            default: begin c = i_sr;  s = -i_cr; end
        endcase
    end

    // Stage 1: four products.
    logic               r_v1;
    logic signed [64:0] r_xc, r_ys, r_xs, r_yc;
    t_side              r_s1;
    // Stage 2: sums and rounding.
    logic               r_v2;
    logic signed [34:0] r_rx, r_ry;
    t_side              r_s2;
    logic signed [65:0] sx, sy;
    // Stage 3: output register.
    logic               r_v3, r_sat;
    t_coord             r_ox, r_oy;
    logic signed [27:0] r_ang;
    logic signed [34:0] fx, fy;
    t_coord             n_ox, n_oy;
    logic               n_sat;

    always_comb begin
        sx = 66'(r_xc) - 66'(r_ys) + (66'sd1 <<< (TrigFrac - 1));
        sy = 66'(r_xs) + 66'(r_yc) + (66'sd1 <<< (TrigFrac - 1));
        fx = r_rx + 35'(r_s2.px);
        fy = r_ry + 35'(r_s2.py);
        n_sat = 1'b0;
        if (fx > 35'sd2147483647) begin
            n_ox = 32'sh7fffffff; n_sat = 1'b1;
        end else if (fx < -35'sd2147483648) begin
            n_ox = 32'sh80000000; n_sat = 1'b1;
        end else n_ox = fx[31:0];
        if (fy > 35'sd2147483647) begin
            n_oy = 32'sh7fffffff; n_sat = 1'b1;
        end else if (fy < -35'sd2147483648) begin
            n_oy = 32'sh80000000; n_sat = 1'b1;
        end else n_oy = fy[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_xc  <= 65'(i_side.dx * c);
            r_ys  <= 65'(i_side.dy * s);
            r_xs  <= 65'(i_side.dx * s);
            r_yc  <= 65'(i_side.dy * c);
            r_s1  <= i_side;
            r_rx  <= 35'(sx >>> TrigFrac);
            r_ry  <= 35'(sy >>> TrigFrac);
            r_s2  <= r_s1;
            r_ox  <= n_ox;
            r_oy  <= n_oy;
            r_sat <= n_sat;
            r_ang <= r_s2.ang;
        end
    end

    assign o_valid     = r_v3;
    assign o_rotated_x = r_ox;
    assign o_rotated_y = r_oy;
    assign o_new_angle = r_ang;
    assign o_saturated = r_sat;
endmodule

// ----- sv/rotate_point_about_pivot.sv -----
// Top level of the point rotation block: front end, CORDIC chain, back end.
// Depends on rpap_pkg, rpap_front, rpap_cordic_stage and rpap_back.
//
// Usage: an input word carries a pivot, a point, a heading and a rotation in
// degrees (signed Q10.16). The block rotates the point clockwise about the
// pivot by the rotation and returns the new point, saturated to 32 bits, the
// new heading, and a flag that is set when a coordinate clipped.
// From acceptance to o_valid a word passes two front stages, one per CORDIC
// iteration (18), and three back stages for products, rounding and saturation.
// Throughput is one word per cycle unless the output stalls. When the receiver
// stalls with a finished word at the output, the whole pipeline holds and
// o_stall is raised, so nothing is lost or repeated. Reset clears all valid bits;
// words are taken from the first cycle after reset.
module rotate_point_about_pivot import rpap_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_coord             i_pivot_x,
    input  t_coord             i_pivot_y,
    input  t_coord             i_point_x,
    input  t_coord             i_point_y,
    input  logic signed [26:0] i_current_angle,
    input  logic signed [25:0] i_rotation,
    output logic               o_valid,
    input  logic               i_stall,
    output t_coord             o_rotated_x,
    output t_coord             o_rotated_y,
    output logic signed [27:0] o_new_angle,
    output logic               o_saturated
);
    // The pipeline advances unless a finished word waits at a stalled output.
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic               v [CordicStages+1];
    t_trig              x [CordicStages+1];
    t_trig              y [CordicStages+1];
    logic signed [31:0] z [CordicStages+1];
    t_side              sd [CordicStages+1];

    rpap_front u_front (
        .i_clk, .i_rst_n, .i_en(en), .i_valid,
        .i_pivot_x, .i_pivot_y, .i_point_x, .i_point_y,
        .i_current_angle, .i_rotation,
        .o_valid(v[0]), .o_z(z[0]), .o_side(sd[0])
    );
    assign x[0] = GainQ28;
    assign y[0] = '0;

    for (genvar g = 0; g < CordicStages; g++) begin : g_cordic
        rpap_cordic_stage u_stage (
            .i_clk, .i_rst_n, .i_en(en), .i_idx(5'(g)),
            .i_valid(v[g]), .i_x(x[g]), .i_y(y[g]), .i_z(z[g]), .i_side(sd[g]),
            .o_valid(v[g+1]), .o_x(x[g+1]), .o_y(y[g+1]), .o_z(z[g+1]),
            .o_side(sd[g+1])
        );
    end

    rpap_back u_back (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v[CordicStages]),
        .i_cr(x[CordicStages]), .i_sr(y[CordicStages]), .i_side(sd[CordicStages]),
        .o_valid, .o_rotated_x, .o_rotated_y, .o_new_angle, .o_saturated
    );
endmodule

// ----- sv/rpap_checker.sv -----
// Port checker for the point rotation block, bound to the top level.
// Depends on rpap_pkg.
module rpap_checker import rpap_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input t_coord             o_rotated_x,
    input logic signed [27:0] o_new_angle
);
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)) else $error("stall without held word");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rotated_x)
                                  && $stable(o_new_angle)))
        else $error("held word changed");
    a_no_stall_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall) else $error("input stalled while output free");
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid) else $error("word after reset");
endmodule

bind rotate_point_about_pivot rpap_checker u_rpap_checker (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall,
    .o_rotated_x, .o_new_angle
);

// ----- test/tb.sv -----
// Testbench for rotate_point_about_pivot: a table of directed words followed by random
// words, checked against a behavioral rotation predictor; fixed rows give their own sat and heading.
// Depends on rpap_pkg and the rotate_point_about_pivot RTL.
module tb import rpap_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = 23;
    localparam int WatchdogLimit = 20000;
    localparam longint Deg1 = 64'sd65536;

    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [27:0] ang;
        logic               sat;
    } t_rotated;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [26:0] ang;
        logic signed [25:0] rot;
        logic               has_fixed;
        logic               fixed_sat;
        logic signed [27:0] fixed_ang;
    } t_directed;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    t_coord             i_pivot_x = '0;
    t_coord             i_pivot_y = '0;
    t_coord             i_point_x = '0;
    t_coord             i_point_y = '0;
    logic signed [26:0] i_current_angle = '0;
    logic signed [25:0] i_rotation = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    t_coord             o_rotated_x;
    t_coord             o_rotated_y;
    logic signed [27:0] o_new_angle;
    logic               o_saturated;

    t_rotated   pending_points[$];
    t_directed  directed_words[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    bit         timed_out = 1'b0;

    rotate_point_about_pivot uut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    // Cosine and sine in Q28 for an angle in Q16.16 degrees.
    function automatic void trig_of_degrees(input longint deg, output longint c,
                                            output longint s);
        longint full_turn, quarter, t, q, r, z, x, y, xs, ys;
        longint atan_tab[32];
        full_turn = 360 * Deg1;
        quarter = 90 * Deg1;
        atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                     33543516, 16775851, 8388437, 4194283, 2097125, 1048570,
                     524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095,
                     2047, 1023, 511, 255, 127, 63, 31, 15, 8, 4, 2, 1, 0};
        t = deg % full_turn;
        if (t < 0) t += full_turn;
        q = t / quarter;
        r = t - q * quarter;
        z = (r * 18740330 + 32768) >>> 16;
        x = 163008219;
        y = 0;
        for (int i = 0; i < 18; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic t_rotated rotate_about_pivot(t_directed w);
        t_rotated res;
        longint px, py, dx, dy, c, s, rx, ry, ang;
        px = w.px; py = w.py;
        dx = longint'(w.qx) - px;
        dy = longint'(w.qy) - py;
        trig_of_degrees(-longint'(w.rot), c, s);
        rx = ((dx * c - dy * s + (64'sd1 <<< 27)) >>> 28) + px;
        ry = ((dx * s + dy * c + (64'sd1 <<< 27)) >>> 28) + py;
        res.sat = 1'b0;
        if (rx > 64'sd2147483647) begin rx = 64'sd2147483647; res.sat = 1'b1; end
        if (rx < -64'sd2147483648) begin rx = -64'sd2147483648; res.sat = 1'b1; end
        if (ry > 64'sd2147483647) begin ry = 64'sd2147483647; res.sat = 1'b1; end
        if (ry < -64'sd2147483648) begin ry = -64'sd2147483648; res.sat = 1'b1; end
        ang = w.ang;
        if (ang > 360 * Deg1) ang -= 360 * Deg1;
        ang += w.rot;
        res.rx = rx[31:0];
        res.ry = ry[31:0];
        res.ang = ang[27:0];
        return res;
    endfunction

    function automatic t_directed word_of(longint px, longint py, longint qx,
                                          longint qy, longint ang, longint rot);
        t_directed w;
        w.px = 32'(px); w.py = 32'(py); w.qx = 32'(qx); w.qy = 32'(qy);
        w.ang = 27'(ang); w.rot = 26'(rot);
        w.has_fixed = 1'b0; w.fixed_sat = 1'b0; w.fixed_ang = '0;
        return w;
    endfunction

    function automatic t_directed fixed_word(longint px, longint py, longint qx,
                                             longint qy, longint ang, longint rot,
                                             logic sat, longint new_ang);
        t_directed w;
        w = word_of(px, py, qx, qy, ang, rot);
        w.has_fixed = 1'b1;
        w.fixed_sat = sat;
        w.fixed_ang = 28'(new_ang);
        return w;
    endfunction

    function automatic longint rand_coord();
        case ($urandom_range(0, 3))
            0: return longint'($signed($urandom()));
            1: return longint'($signed($urandom_range(0, 2000000))) - 1000000;
            2: return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
            default: return (longint'($urandom_range(0, 4000)) - 2000) * Deg1;
        endcase
    endfunction

    function automatic t_directed random_word();
        longint ang, rot;
        case ($urandom_range(0, 3))
            0: rot = (longint'($urandom_range(0, 720)) - 360) * Deg1;
            1: rot = longint'($urandom_range(0, 47185920)) - 23592960;
            2: rot = (longint'($urandom_range(0, 8)) - 4) * 90 * Deg1;
            default: rot = longint'($urandom_range(0, 200)) - 100;
        endcase
        if ($urandom_range(0, 3) == 0)
            ang = $urandom_range(0, 1) ? 64'sd47185920 : -64'sd47185920;
        else
            ang = longint'($urandom_range(0, 94371840)) - 47185920;
        return word_of(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       ang, rot);
    endfunction

    // Sender idle and receiver stall phases, changed every 110 words.
    function automatic void set_phase(int n);
        case ((n / 110) % 5)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            3: begin send_idle_pct = 6;  stall_pct = 6;  end
            default: begin send_idle_pct = 0; stall_pct = 0; end
        endcase
    endfunction

    task automatic send_word(t_directed w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_pivot_x <= w.px;
        i_pivot_y <= w.py;
        i_point_x <= w.qx;
        i_point_y <= w.qy;
        i_current_angle <= w.ang;
        i_rotation <= w.rot;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        begin
            t_rotated e;
            e = rotate_about_pivot(w);
            if (w.has_fixed && (e.sat !== w.fixed_sat || e.ang !== w.fixed_ang))
                $display("predictor disagrees with table row: sat %0b ang %0d",
                         e.sat, e.ang);
            if (w.has_fixed) begin
                e.sat = w.fixed_sat;
                e.ang = w.fixed_ang;
            end
            pending_points.push_back(e);
        end
        @(negedge i_clk);
    endtask

    // Receiver stall, changed at each falling edge.
    always @(negedge i_clk)
        i_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                t_rotated e;
                e = pending_points.pop_front();
                if (o_rotated_x !== e.rx || o_rotated_y !== e.ry
                        || o_new_angle !== e.ang || o_saturated !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x %0d y %0d ang %0d sat %0b, got x %0d y %0d ang %0d sat %0b",
                                 e.rx, e.ry, e.ang, e.sat, o_rotated_x,
                                 o_rotated_y, o_new_angle, o_saturated);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int drain;
        // Rows with sat and heading read off directly: zero offsets, and small offsets
        // about the origin, never clip, and the heading is reduced only when above one full turn.
        directed_words.push_back(fixed_word(0, 0, 0, 0, 0, 0, 0, 0));
        directed_words.push_back(fixed_word(0, 0, 65536, 0, 0, 5898240, 0, 5898240));
        directed_words.push_back(fixed_word(0, 0, 65536, 0, 0, -5898240, 0, -5898240));
        directed_words.push_back(fixed_word(0, 0, 0, 65536, 0, 11796480, 0, 11796480));
        directed_words.push_back(fixed_word(5, 7, 5, 7, 47185920, 23592960,
                                            0, 47185920));
        directed_words.push_back(fixed_word(5, 7, 5, 7, -47185920, -23592960,
                                            0, -70778880));
        directed_words.push_back(fixed_word(0, 0, 0, 0, 23592960, 0, 0, 23592960));
        directed_words.push_back(fixed_word(0, 0, 0, 0, 23592961, 0, 0, 1));
        directed_words.push_back(fixed_word(-2147483648, 2147483647, -2147483648,
                                            2147483647, 0, 65536, 0, 65536));
        // Extremes that push the result out of range, then small offsets at or near quadrant edges.
        directed_words.push_back(word_of(-2147483648, -2147483648, 2147483647,
                                         2147483647, 0, 2949120));
        directed_words.push_back(word_of(2147483647, 2147483647, -2147483648,
                                         -2147483648, 0, -11796480));
        directed_words.push_back(word_of(2147483647, 0, -2147483648, 0, 0, 11796480));
        directed_words.push_back(word_of(0, 0, 2147483647, 2147483647, 0, 2949120));
        directed_words.push_back(word_of(0, 0, 2147483647, -2147483648, 0, -2949120));
        directed_words.push_back(word_of(0, 0, 65536, 65536, 0, 1));
        directed_words.push_back(word_of(0, 0, 65536, 65536, 0, -1));
        directed_words.push_back(word_of(100, -100, -65536, 131072, 0, 17694720));
        directed_words.push_back(word_of(0, 0, 65536, 0, 0, 23592959));
        directed_words.push_back(word_of(0, 0, 65536, 0, 0, -23592959));
        directed_words.push_back(word_of(0, 0, 65536, 0, 0, 5898239));
        directed_words.push_back(word_of(0, 0, 65536, 0, 0, 5898241));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_words[k]) send_word(directed_words[k]);
        for (int n = 0; n < 550; n++) begin
            set_phase(n);
            send_word(random_word());
        end
        i_valid <= 1'b0;

        drain = 0;
        while (pending_points.size() != 0 && drain < WatchdogLimit) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (Latency + 10) @(posedge i_clk);
        if (mismatches == 0 && pending_points.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
